@@ hdl/nicr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the single-buffer NIC register block.
// Used by nicr_core and single_buffer_nic_registers_top; no dependencies.
package nicr_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_POLL  = 2'd2;

    localparam logic [1:0] CFG_LINK_UP = 2'd0;
    localparam logic [1:0] CFG_MSI     = 2'd1;
    localparam logic [1:0] CFG_MAC     = 2'd2;

    localparam logic [11:0] OFF_TX_BASE_LO = 12'h000;
    localparam logic [11:0] OFF_TX_BASE_HI = 12'h004;
    localparam logic [11:0] OFF_TX_LEN     = 12'h008;
    localparam logic [11:0] OFF_TX_BELL    = 12'h00C;
    localparam logic [11:0] OFF_RX_BASE_LO = 12'h010;
    localparam logic [11:0] OFF_RX_BASE_HI = 12'h014;
    localparam logic [11:0] OFF_RX_LEN     = 12'h018;
    localparam logic [11:0] OFF_RX_STATUS  = 12'h01C;
    localparam logic [11:0] OFF_INT_CAUSE  = 12'h020;
    localparam logic [11:0] OFF_INT_ENABLE = 12'h024;
    localparam logic [11:0] OFF_LINK       = 12'h028;
    localparam logic [11:0] OFF_MAC_LO     = 12'h02C;
    localparam logic [11:0] OFF_MAC_HI     = 12'h030;

    localparam logic [1:0] IRQ_RX_DONE = 2'b01;
    localparam logic [1:0] IRQ_TX_DONE = 2'b10;

    localparam logic [47:0] MAC_RESET = 48'h0049_4143_4802;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] reg_offset;
        logic [31:0] write_data;
        logic        wire_frame_waiting;
        logic [13:0] wire_frame_len;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        frame_taken;
        logic        rx_dma_start;
        logic [63:0] rx_dma_addr;
        logic [13:0] rx_dma_len;
        logic        tx_dma_start;
        logic [63:0] tx_dma_addr;
        logic [13:0] tx_dma_len;
        logic        tx_to_wire;
        logic        irq_level;
        logic        msi_pulse;
        logic        guest_error;
    } t_out_item;

    typedef struct packed {
        logic        link_up;
        logic        msi_mode;
        logic [47:0] mac_address;
    } t_cfg;

endpackage

@@ hdl/nicr_core.sv @@
`timescale 1ns / 1ps
// Register file and request decode of the NIC register block.
// Depends on nicr_pkg; instantiated by single_buffer_nic_registers_top.
module nicr_core #(
    parameter int MAX_FRAME_BYTES = 9216,
    parameter int REG_SPACE_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  nicr_pkg::t_in_item i_item,
    input  nicr_pkg::t_cfg     i_cfg,
    output nicr_pkg::t_out_item o_result
);

    localparam logic [13:0] MaxLen   = 14'(MAX_FRAME_BYTES);
    localparam logic [12:0] SpaceEnd = 13'(REG_SPACE_BYTES);

    logic [31:0] r_tx_base_lo, n_tx_base_lo;
    logic [31:0] r_tx_base_hi, n_tx_base_hi;
    logic [31:0] r_tx_len,     n_tx_len;
    logic [31:0] r_rx_base_lo, n_rx_base_lo;
    logic [31:0] r_rx_base_hi, n_rx_base_hi;
    logic [13:0] r_rx_len,     n_rx_len;
    logic        r_rx_ready,   n_rx_ready;
    logic [1:0]  r_pending,    n_pending;
    logic [31:0] r_mask,       n_mask;
    logic        r_irq_line,   n_irq_line;

    logic [13:0] len_sat;
    logic [63:0] rx_addr;
    logic        frame_ok;
    logic        in_space;
    logic        do_intake;
    logic        do_refresh;
    logic [1:0]  irq_active;

    assign len_sat  = (i_item.wire_frame_len > MaxLen) ? MaxLen : i_item.wire_frame_len;
    assign rx_addr  = {r_rx_base_hi, r_rx_base_lo};
    assign frame_ok = i_cfg.link_up && i_item.wire_frame_waiting
                      && (i_item.wire_frame_len != 14'd0);
    assign in_space = {1'b0, i_item.reg_offset} < SpaceEnd;

    always_comb begin
        n_tx_base_lo = r_tx_base_lo;
        n_tx_base_hi = r_tx_base_hi;
        n_tx_len     = r_tx_len;
        n_rx_base_lo = r_rx_base_lo;
        n_rx_base_hi = r_rx_base_hi;
        n_rx_len     = r_rx_len;
        n_rx_ready   = r_rx_ready;
        n_pending    = r_pending;
        n_mask       = r_mask;
        n_irq_line   = r_irq_line;
        o_result     = '0;
        do_intake    = 1'b0;
        do_refresh   = 1'b0;

        case (i_item.cmd)
            nicr_pkg::CMD_READ: begin
                if (!in_space) begin
                    o_result.guest_error = 1'b1;
                end else begin
                    case (i_item.reg_offset)
                        nicr_pkg::OFF_TX_BASE_LO: o_result.read_data = r_tx_base_lo;
                        nicr_pkg::OFF_TX_BASE_HI: o_result.read_data = r_tx_base_hi;
                        nicr_pkg::OFF_TX_LEN:     o_result.read_data = r_tx_len;
                        nicr_pkg::OFF_RX_BASE_LO: o_result.read_data = r_rx_base_lo;
                        nicr_pkg::OFF_RX_BASE_HI: o_result.read_data = r_rx_base_hi;
                        nicr_pkg::OFF_RX_LEN:     o_result.read_data = {18'd0, r_rx_len};
                        nicr_pkg::OFF_RX_STATUS: begin
                            do_intake = !r_rx_ready && frame_ok;
                            o_result.read_data =
                                {31'd0, r_rx_ready || (do_intake && rx_addr != 64'd0)};
                        end
                        nicr_pkg::OFF_INT_CAUSE:  o_result.read_data = {30'd0, r_pending};
                        nicr_pkg::OFF_INT_ENABLE: o_result.read_data = r_mask;
                        nicr_pkg::OFF_LINK:       o_result.read_data = {31'd0, i_cfg.link_up};
                        nicr_pkg::OFF_MAC_LO:     o_result.read_data = i_cfg.mac_address[31:0];
                        nicr_pkg::OFF_MAC_HI:
                            o_result.read_data = {16'd0, i_cfg.mac_address[47:32]};
                        default: o_result.guest_error = 1'b1;
                    endcase
                end
            end
            nicr_pkg::CMD_WRITE: begin
                if (!in_space) begin
                    o_result.guest_error = 1'b1;
                end else begin
                    case (i_item.reg_offset)
                        nicr_pkg::OFF_TX_BASE_LO: n_tx_base_lo = i_item.write_data;
                        nicr_pkg::OFF_TX_BASE_HI: n_tx_base_hi = i_item.write_data;
                        nicr_pkg::OFF_TX_LEN:     n_tx_len     = i_item.write_data;
                        nicr_pkg::OFF_TX_BELL: begin
                            if (r_tx_len == 32'd0 || r_tx_len > {18'd0, MaxLen}) begin
                                o_result.guest_error = 1'b1;
                            end else begin
                                o_result.tx_dma_start = 1'b1;
                                o_result.tx_dma_addr  = {r_tx_base_hi, r_tx_base_lo};
                                o_result.tx_dma_len   = r_tx_len[13:0];
                                o_result.tx_to_wire   = i_cfg.link_up;
                                n_pending             = r_pending | nicr_pkg::IRQ_TX_DONE;
                                do_refresh            = 1'b1;
                            end
                        end
                        nicr_pkg::OFF_RX_BASE_LO: n_rx_base_lo = i_item.write_data;
                        nicr_pkg::OFF_RX_BASE_HI: n_rx_base_hi = i_item.write_data;
                        nicr_pkg::OFF_RX_STATUS: begin
                            if (i_item.write_data == 32'd0) begin
                                n_rx_ready = 1'b0;
                                do_intake  = frame_ok;
                            end
                        end
                        nicr_pkg::OFF_INT_CAUSE: begin
                            n_pending  = r_pending & ~i_item.write_data[1:0];
                            do_refresh = 1'b1;
                        end
                        nicr_pkg::OFF_INT_ENABLE: begin
                            n_mask     = i_item.write_data;
                            do_refresh = 1'b1;
                        end
                        default: o_result.guest_error = 1'b1;
                    endcase
                end
            end
            nicr_pkg::CMD_POLL: do_intake = !r_rx_ready && frame_ok;
            default: ;
        endcase

        if (do_intake) begin
            o_result.frame_taken = 1'b1;
            if (rx_addr != 64'd0) begin
                o_result.rx_dma_start = 1'b1;
                o_result.rx_dma_addr  = rx_addr;
                o_result.rx_dma_len   = len_sat;
                n_rx_len              = len_sat;
                n_rx_ready            = 1'b1;
                n_pending             = n_pending | nicr_pkg::IRQ_RX_DONE;
                do_refresh            = 1'b1;
            end
        end

        irq_active = n_pending & n_mask[1:0];
        if (do_refresh) begin
            if (i_cfg.msi_mode) begin
                o_result.msi_pulse = (irq_active != 2'b00);
            end else begin
                n_irq_line = (irq_active != 2'b00);
            end
        end
        o_result.irq_level = n_irq_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_base_lo <= '0;
            r_tx_base_hi <= '0;
            r_tx_len     <= '0;
            r_rx_base_lo <= '0;
            r_rx_base_hi <= '0;
            r_rx_len     <= '0;
            r_rx_ready   <= 1'b0;
            r_pending    <= '0;
            r_mask       <= '0;
            r_irq_line   <= 1'b0;
        end else if (i_fire) begin
            r_tx_base_lo <= n_tx_base_lo;
            r_tx_base_hi <= n_tx_base_hi;
            r_tx_len     <= n_tx_len;
            r_rx_base_lo <= n_rx_base_lo;
            r_rx_base_hi <= n_rx_base_hi;
            r_rx_len     <= n_rx_len;
            r_rx_ready   <= n_rx_ready;
            r_pending    <= n_pending;
            r_mask       <= n_mask;
            r_irq_line   <= n_irq_line;
        end
    end

endmodule

@@ hdl/single_buffer_nic_registers_top.sv @@
`timescale 1ns / 1ps
// Top level of the single-buffer NIC register block: request and result
// registers, configuration registers. Depends on nicr_pkg and nicr_core.
//
// Takes one request (bus read, bus write or wire poll) per clock while the
// result side does not stall, and returns exactly one result per request, in
// order. A request is latched in the request register, decoded against the
// register file by nicr_core, and the result is held in the result register;
// the register file updates in the same cycle, so back-to-back requests see
// each other's effects. The configuration port (link_up, msi_mode,
// mac_address) is always ready and is meant to be written while no request
// is in flight.
module single_buffer_nic_registers_top #(
    parameter int MAX_FRAME_BYTES = 9216,
    parameter int REG_SPACE_BYTES = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  nicr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output nicr_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_data
);

    logic                r_req_valid;
    nicr_pkg::t_in_item  r_req;
    logic                r_out_valid;
    nicr_pkg::t_out_item r_out;
    nicr_pkg::t_cfg      r_cfg;
    nicr_pkg::t_out_item core_result;
    logic                advance;
    logic                in_fire;

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_req_valid && !advance;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    nicr_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .REG_SPACE_BYTES(REG_SPACE_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (r_req_valid && advance),
        .i_item  (r_req),
        .i_cfg   (r_cfg),
        .o_result(core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_req_valid <= 1'b1;
            end else if (advance) begin
                r_req_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_req_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req <= i_in_item;
        end
        if (advance && r_req_valid) begin
            r_out <= core_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_up     <= 1'b0;
            r_cfg.msi_mode    <= 1'b0;
            r_cfg.mac_address <= nicr_pkg::MAC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                nicr_pkg::CFG_LINK_UP: r_cfg.link_up     <= i_cfg_data[0];
                nicr_pkg::CFG_MSI:     r_cfg.msi_mode    <= i_cfg_data[0];
                nicr_pkg::CFG_MAC:     r_cfg.mac_address <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ tb/sv/single_buffer_nic_registers_top_test.sv @@
`timescale 1ns / 1ps
// Testbench of single_buffer_nic_registers_top: queue-fed request driver, result monitor
// checked against an in-bench register model, config phases. Depends on nicr_pkg.
module single_buffer_nic_registers_top_test;

    localparam int          FRAME_MAX  = 9216;
    localparam int          IDLE_LIMIT = 1000;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam logic [11:0] REG_MAP [13] = '{
        nicr_pkg::OFF_TX_BASE_LO, nicr_pkg::OFF_TX_BASE_HI, nicr_pkg::OFF_TX_LEN,
        nicr_pkg::OFF_TX_BELL, nicr_pkg::OFF_RX_BASE_LO, nicr_pkg::OFF_RX_BASE_HI,
        nicr_pkg::OFF_RX_LEN, nicr_pkg::OFF_RX_STATUS, nicr_pkg::OFF_INT_CAUSE,
        nicr_pkg::OFF_INT_ENABLE, nicr_pkg::OFF_LINK, nicr_pkg::OFF_MAC_LO,
        nicr_pkg::OFF_MAC_HI};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    nicr_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    nicr_pkg::t_out_item o_out_item;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = '0;
    logic [47:0]         i_cfg_data = '0;

    single_buffer_nic_registers_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // register model
    logic                nic_link_up;
    logic                nic_msi_mode;
    logic [47:0]         nic_mac;
    logic [31:0]         tx_base_lo, tx_base_hi, tx_len;
    logic [31:0]         rx_base_lo, rx_base_hi;
    logic [13:0]         rx_len;
    logic                rx_ready;
    logic [1:0]          int_cause;
    logic [31:0]         int_enable;
    logic                irq_line;
    nicr_pkg::t_out_item step_res;

    nicr_pkg::t_in_item  req_fifo [$];
    nicr_pkg::t_out_item rsp_expect [$];

    int  queued_total = 0;
    int  req_accepted = 0;
    int  rsp_seen = 0;
    int  fail_count = 0;
    int  idle_cycles = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  n_tx_start = 0;
    int  n_rx_start = 0;
    int  n_dropped = 0;
    int  n_guest_err = 0;
    bit  idle_on = 1'b1;
    bit  in_taken = 1'b0;

    task automatic report_fail(string msg);
        fail_count++;
        $display("MISMATCH: %s", msg);
    endtask

    task automatic cmp(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_fail($sformatf("result %0d %s: got %0h expected %0h",
                                  rsp_seen, name, got, want));
    endtask

    function automatic void irq_refresh();
        logic [31:0] pend;
        pend = {30'd0, int_cause} & int_enable;
        if (nic_msi_mode) begin
            if (pend != 0)
                step_res.msi_pulse = 1'b1;
        end else begin
            irq_line = (pend != 0);
        end
    endfunction

    function automatic void frame_intake(nicr_pkg::t_in_item it);
        logic [13:0] len;
        logic [63:0] addr;
        len = it.wire_frame_len;
        if (!nic_link_up || rx_ready || !it.wire_frame_waiting || len == 0)
            return;
        if (len > FRAME_MAX)
            len = 14'(FRAME_MAX);
        step_res.frame_taken = 1'b1;
        addr = {rx_base_hi, rx_base_lo};
        if (addr == 0) begin
            n_dropped++;
            return;
        end
        step_res.rx_dma_start = 1'b1;
        step_res.rx_dma_addr  = addr;
        step_res.rx_dma_len   = len;
        rx_len    = len;
        rx_ready  = 1'b1;
        int_cause = int_cause | nicr_pkg::IRQ_RX_DONE;
        n_rx_start++;
        irq_refresh();
    endfunction

    function automatic nicr_pkg::t_out_item nic_step(nicr_pkg::t_in_item it);
        logic [31:0] d;
        step_res = '0;
        d = it.write_data;
        case (it.cmd)
            nicr_pkg::CMD_READ: begin
                case (it.reg_offset)
                    nicr_pkg::OFF_TX_BASE_LO: step_res.read_data = tx_base_lo;
                    nicr_pkg::OFF_TX_BASE_HI: step_res.read_data = tx_base_hi;
                    nicr_pkg::OFF_TX_LEN:     step_res.read_data = tx_len;
                    nicr_pkg::OFF_RX_BASE_LO: step_res.read_data = rx_base_lo;
                    nicr_pkg::OFF_RX_BASE_HI: step_res.read_data = rx_base_hi;
                    nicr_pkg::OFF_RX_LEN:     step_res.read_data = {18'd0, rx_len};
                    nicr_pkg::OFF_RX_STATUS: begin
                        frame_intake(it);
                        step_res.read_data = {31'd0, rx_ready};
                    end
                    nicr_pkg::OFF_INT_CAUSE:  step_res.read_data = {30'd0, int_cause};
                    nicr_pkg::OFF_INT_ENABLE: step_res.read_data = int_enable;
                    nicr_pkg::OFF_LINK:       step_res.read_data = {31'd0, nic_link_up};
                    nicr_pkg::OFF_MAC_LO:     step_res.read_data = nic_mac[31:0];
                    nicr_pkg::OFF_MAC_HI:     step_res.read_data = {16'd0, nic_mac[47:32]};
                    default:                  step_res.guest_error = 1'b1;
                endcase
            end
            nicr_pkg::CMD_WRITE: begin
                case (it.reg_offset)
                    nicr_pkg::OFF_TX_BASE_LO: tx_base_lo = d;
                    nicr_pkg::OFF_TX_BASE_HI: tx_base_hi = d;
                    nicr_pkg::OFF_TX_LEN:     tx_len = d;
                    nicr_pkg::OFF_TX_BELL: begin
                        if (tx_len == 0 || tx_len > FRAME_MAX) begin
                            step_res.guest_error = 1'b1;
                        end else begin
                            step_res.tx_dma_start = 1'b1;
                            step_res.tx_dma_addr  = {tx_base_hi, tx_base_lo};
                            step_res.tx_dma_len   = tx_len[13:0];
                            step_res.tx_to_wire   = nic_link_up;
                            int_cause = int_cause | nicr_pkg::IRQ_TX_DONE;
                            n_tx_start++;
                            irq_refresh();
                        end
                    end
                    nicr_pkg::OFF_RX_BASE_LO: rx_base_lo = d;
                    nicr_pkg::OFF_RX_BASE_HI: rx_base_hi = d;
                    nicr_pkg::OFF_RX_STATUS: begin
                        if (d == 0) begin
                            rx_ready = 1'b0;
                            frame_intake(it);
                        end
                    end
                    nicr_pkg::OFF_INT_CAUSE: begin
                        int_cause = int_cause & ~d[1:0];
                        irq_refresh();
                    end
                    nicr_pkg::OFF_INT_ENABLE: begin
                        int_enable = d;
                        irq_refresh();
                    end
                    default: step_res.guest_error = 1'b1;
                endcase
            end
            nicr_pkg::CMD_POLL: frame_intake(it);
            default: ;
        endcase
        if (step_res.guest_error)
            n_guest_err++;
        step_res.irq_level = irq_line;
        return step_res;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // request driver
    always @(negedge i_clk) begin
        logic               v;
        nicr_pkg::t_in_item it;
        v  = i_in_valid;
        it = i_in_item;
        if (in_taken)
            v = 1'b0;
        if (i_rst_n && !v) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
            end else if (req_fifo.size() > 0) begin
                it = req_fifo.pop_front();
                v  = 1'b1;
                send_gap = draw_gap();
            end
        end
        i_in_valid <= v;
        i_in_item  <= it;
    end

    // result-side stall
    always @(negedge i_clk) begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (idle_on && $urandom_range(0, 99) < 20)
            stall_left = draw_gap() + 1;
        i_out_stall <= (stall_left > 0);
    end

    // monitor, model update and watchdog
    always @(posedge i_clk) begin
        nicr_pkg::t_out_item want;
        bit                  busy;
        busy     = 1'b0;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                busy = 1'b1;
                case (i_cfg_index)
                    nicr_pkg::CFG_LINK_UP: nic_link_up  = i_cfg_data[0];
                    nicr_pkg::CFG_MSI:     nic_msi_mode = i_cfg_data[0];
                    nicr_pkg::CFG_MAC:     nic_mac      = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                busy = 1'b1;
                rsp_seen++;
                if (rsp_expect.size() == 0) begin
                    report_fail($sformatf("result %0d arrived with nothing expected", rsp_seen));
                end else begin
                    want = rsp_expect.pop_front();
                    cmp("read_data",    64'(o_out_item.read_data),    64'(want.read_data));
                    cmp("frame_taken",  64'(o_out_item.frame_taken),  64'(want.frame_taken));
                    cmp("rx_dma_start", 64'(o_out_item.rx_dma_start), 64'(want.rx_dma_start));
                    cmp("rx_dma_addr",  o_out_item.rx_dma_addr,       want.rx_dma_addr);
                    cmp("rx_dma_len",   64'(o_out_item.rx_dma_len),   64'(want.rx_dma_len));
                    cmp("tx_dma_start", 64'(o_out_item.tx_dma_start), 64'(want.tx_dma_start));
                    cmp("tx_dma_addr",  o_out_item.tx_dma_addr,       want.tx_dma_addr);
                    cmp("tx_dma_len",   64'(o_out_item.tx_dma_len),   64'(want.tx_dma_len));
                    cmp("tx_to_wire",   64'(o_out_item.tx_to_wire),   64'(want.tx_to_wire));
                    cmp("irq_level",    64'(o_out_item.irq_level),    64'(want.irq_level));
                    cmp("msi_pulse",    64'(o_out_item.msi_pulse),    64'(want.msi_pulse));
                    cmp("guest_error",  64'(o_out_item.guest_error),  64'(want.guest_error));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                busy     = 1'b1;
                in_taken = 1'b1;
                req_accepted++;
                rsp_expect.push_back(nic_step(i_in_item));
            end
        end
        idle_cycles = busy ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d results pending",
                     IDLE_LIMIT, rsp_expect.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_req(logic [1:0] c, logic [11:0] o, logic [31:0] d,
                            logic w, logic [13:0] l);
        nicr_pkg::t_in_item it;
        it.cmd                = c;
        it.reg_offset         = o;
        it.write_data         = d;
        it.wire_frame_waiting = w;
        it.wire_frame_len     = l;
        req_fifo.push_back(it);
        queued_total++;
    endtask

    task automatic push_rnd(logic [1:0] c, logic [11:0] o, logic [31:0] d);
        logic [13:0] l;
        int          r;
        r = $urandom_range(0, 9);
        if (r == 0)
            l = 14'd0;
        else if (r == 1)
            l = 14'($urandom_range(0, 16383));
        else if (r == 2)
            l = 14'($urandom_range(9200, 9300));
        else
            l = 14'($urandom_range(1, 1518));
        push_req(c, o, d, $urandom_range(0, 3) != 0, l);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [47:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (req_fifo.size() != 0 || i_in_valid || rsp_expect.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic gen_traffic(int n);
        int          target;
        int          r;
        logic [31:0] d;
        target = queued_total + n;
        while (queued_total < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_TX_BASE_LO, $urandom);
                    if ($urandom_range(0, 1))
                        push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_TX_BASE_HI,
                                 $urandom_range(0, 1) ? $urandom : 32'd0);
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        d = 32'd0;
                    else if (r == 1)
                        d = $urandom;
                    else if (r == 2)
                        d = $urandom_range(FRAME_MAX, FRAME_MAX + 1);
                    else
                        d = $urandom_range(1, FRAME_MAX);
                    push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_TX_LEN, d);
                    push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_TX_BELL, $urandom);
                    if ($urandom_range(0, 1))
                        push_rnd(nicr_pkg::CMD_READ, nicr_pkg::OFF_INT_CAUSE, $urandom);
                    push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_INT_CAUSE, $urandom);
                end
                3, 4, 5: begin
                    if ($urandom_range(0, 3) == 0) begin
                        if ($urandom_range(0, 2) == 0) begin
                            push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_RX_BASE_LO, 32'd0);
                            push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_RX_BASE_HI, 32'd0);
                        end else begin
                            push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_RX_BASE_LO, $urandom);
                            push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_RX_BASE_HI,
                                     $urandom_range(0, 1) ? $urandom : 32'd0);
                        end
                    end
                    case ($urandom_range(0, 2))
                        0: push_rnd(nicr_pkg::CMD_POLL, 12'($urandom_range(0, 4095)),
                                    $urandom);
                        1: push_rnd(nicr_pkg::CMD_READ, nicr_pkg::OFF_RX_STATUS, $urandom);
                        default: push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_RX_STATUS,
                                          32'd0);
                    endcase
                    push_rnd(nicr_pkg::CMD_READ, nicr_pkg::OFF_RX_LEN, $urandom);
                    push_rnd(nicr_pkg::CMD_READ, nicr_pkg::OFF_INT_CAUSE, $urandom);
                    push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_INT_CAUSE, $urandom);
                    push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_RX_STATUS,
                             $urandom_range(0, 4) == 0 ? $urandom : 32'd0);
                end
                6: begin
                    r = $urandom_range(0, 3);
                    if (r == 0)
                        d = 32'hFFFF_FFFF;
                    else if (r == 1)
                        d = 32'd0;
                    else if (r == 2)
                        d = $urandom;
                    else
                        d = $urandom_range(0, 3);
                    push_rnd(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_INT_ENABLE, d);
                    push_rnd(nicr_pkg::CMD_READ, nicr_pkg::OFF_INT_ENABLE, $urandom);
                    push_rnd(nicr_pkg::CMD_READ, nicr_pkg::OFF_LINK, $urandom);
                    push_rnd(nicr_pkg::CMD_READ,
                             $urandom_range(0, 1) ? nicr_pkg::OFF_MAC_LO : nicr_pkg::OFF_MAC_HI,
                             $urandom);
                end
                7: push_rnd($urandom_range(0, 1) ? nicr_pkg::CMD_READ : nicr_pkg::CMD_WRITE,
                            REG_MAP[$urandom_range(0, 12)], $urandom);
                8: push_rnd(2'($urandom_range(0, 3)), REG_MAP[$urandom_range(0, 12)] +
                            12'($urandom_range(1, 3)), $urandom);
                default: push_rnd(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                                  $urandom);
            endcase
        end
    endtask

    task automatic run_phase(logic link, logic msi, logic [47:0] mac, bit idle, int n);
        drain();
        cfg_write(nicr_pkg::CFG_LINK_UP, {47'd0, link});
        cfg_write(nicr_pkg::CFG_MSI, {47'd0, msi});
        cfg_write(nicr_pkg::CFG_MAC, mac);
        idle_on = idle;
        gen_traffic(n);
    endtask

    initial begin
        logic [63:0] r64;
        nic_link_up  = 1'b0;
        nic_msi_mode = 1'b0;
        nic_mac      = nicr_pkg::MAC_RESET;
        tx_base_lo   = '0;
        tx_base_hi   = '0;
        tx_len       = '0;
        rx_base_lo   = '0;
        rx_base_hi   = '0;
        rx_len       = '0;
        rx_ready     = 1'b0;
        int_cause    = '0;
        int_enable   = '0;
        irq_line     = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults after reset, link down
        push_req(nicr_pkg::CMD_READ,  nicr_pkg::OFF_MAC_LO,  32'd0, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_READ,  nicr_pkg::OFF_MAC_HI,  32'd0, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_READ,  nicr_pkg::OFF_LINK,    32'd0, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_POLL,  12'h000,               32'd0, 1'b1, 14'd64);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_TX_BELL, 32'd0, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_READ,  12'hFFF,               32'd0, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_LINK,    32'hFFFF_FFFF, 1'b0, 14'd0);

        drain();
        cfg_write(nicr_pkg::CFG_LINK_UP, 48'd1);
        cfg_write(nicr_pkg::CFG_MSI, 48'd0);
        cfg_write(nicr_pkg::CFG_MAC, 48'd0);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_INT_ENABLE, 32'hFFFF_FFFF, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_TX_BASE_LO, 32'hFFFF_FFFF, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_TX_BASE_HI, 32'hFFFF_FFFF, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_TX_LEN, 32'(FRAME_MAX), 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_TX_BELL, 32'd0, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_TX_LEN, 32'(FRAME_MAX + 1), 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_TX_BELL, 32'd0, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_POLL,  12'h000, 32'd0, 1'b1, 14'd100);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_RX_BASE_LO, 32'd1, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_POLL,  12'h000, 32'd0, 1'b1, 14'h3FFF);
        push_req(nicr_pkg::CMD_POLL,  12'h000, 32'd0, 1'b1, 14'd60);
        push_req(nicr_pkg::CMD_READ,  nicr_pkg::OFF_RX_LEN,    32'd0, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_READ,  nicr_pkg::OFF_RX_STATUS, 32'd0, 1'b1, 14'd60);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_RX_STATUS, 32'd5, 1'b1, 14'd60);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_RX_STATUS, 32'd0, 1'b1, 14'd1);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_INT_CAUSE, 32'd3, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_READ,  nicr_pkg::OFF_INT_CAUSE, 32'd0, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_WRITE, nicr_pkg::OFF_RX_STATUS, 32'd0, 1'b0, 14'd0);
        push_req(nicr_pkg::CMD_READ,  nicr_pkg::OFF_RX_STATUS, 32'd0, 1'b1, 14'd0);
        push_req(CMD_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 14'd9216);

        run_phase(1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, 250);
        r64 = {$urandom, $urandom};
        run_phase(1'b1, 1'b0, r64[47:0], 1'b0, 250);
        r64 = {$urandom, $urandom};
        run_phase(1'b0, 1'b0, r64[47:0], 1'b1, 200);
        r64 = {$urandom, $urandom};
        run_phase(1'b1, 1'b1, r64[47:0], 1'b1, 250);
        run_phase(1'b1, 1'b0, nicr_pkg::MAC_RESET, 1'b1, 250);
        drain();

        if (rsp_expect.size() != 0)
            report_fail($sformatf("%0d results never arrived", rsp_expect.size()));
        $display("Covered %0d requests over 7 config phases, %0d results checked",
                 req_accepted, rsp_seen);
        $display("TX DMA starts %0d, RX DMA starts %0d, frames dropped %0d, guest errors %0d",
                 n_tx_start, n_rx_start, n_dropped, n_guest_err);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
